@@ design/assert_macros.svh @@
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HIK_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define HIK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ design/heap_ik_pkg.sv @@
// ----------------------------------------------------------------------------
// heap_ik_pkg
// Shared constants and types for the heap increase-key block.
// ----------------------------------------------------------------------------
`default_nettype none

package heap_ik_pkg;

  localparam int HEAP_DEPTH = 1024;
  localparam int VALUE_BITS = 32;
  localparam int ADDR_BITS  = $clog2(HEAP_DEPTH);
  localparam int POS_BITS   = 11;
  localparam int FUNC_BITS  = 2;

  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [POS_BITS-1:0]   pos_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [FUNC_BITS-1:0]  func_t;

  localparam func_t FUNC_LOAD     = 2'd0;
  localparam func_t FUNC_INCREASE = 2'd1;
  localparam func_t FUNC_READ     = 2'd2;
  localparam func_t FUNC_NONE     = 2'd3;

  localparam pos_t POS_ROOT  = pos_t'(1);
  localparam pos_t POS_LIMIT = pos_t'(HEAP_DEPTH);

endpackage

`default_nettype wire

@@ design/heap_increase_key_sift_up_core.sv @@
// ----------------------------------------------------------------------------
// heap_increase_key_sift_up_core
// Max-heap store with load, read and increase-key with sift-up.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_stall   in_func, in_position, in_amount
// out_      output     out_valid / out_stall out_final_position, out_read_value,
//                                            out_error
//
// Load, error and unused items pass through EXEC and DONE; read adds FETCH.
// Increase goes EXEC, FETCH, then DONE at the root; elsewhere it repeats CMP
// once per level climbed, then PLACE if it reaches the root, and DONE. The store
// has one write port and one registered read port: one level a cycle.
// Synchronous active-low reset clears control only; the store is undefined.
// A stalled result holds in the output register; the next request is taken
// while it waits, and a finished result waits in place until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module heap_increase_key_sift_up_core (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [1:0]                   in_func,
  input  wire  [10:0]                  in_position,
  input  wire  [31:0]                  in_amount,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [10:0]                  out_final_position,
  output logic [31:0]                  out_read_value,
  output logic                         out_error
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_PLACE = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;

  heap_ik_pkg::func_t func_r, func_nxt;
  heap_ik_pkg::pos_t  pos_r, pos_nxt;
  heap_ik_pkg::val_t  amt_r, amt_nxt;
  heap_ik_pkg::val_t  cur_r, cur_nxt;

  heap_ik_pkg::pos_t  res_pos_r, res_pos_nxt;
  heap_ik_pkg::val_t  res_val_r, res_val_nxt;
  logic               res_err_r, res_err_nxt;

  logic               out_valid_r, out_valid_nxt;
  heap_ik_pkg::pos_t  out_pos_r, out_pos_nxt;
  heap_ik_pkg::val_t  out_val_r, out_val_nxt;
  logic               out_err_r, out_err_nxt;

  heap_ik_pkg::val_t  mem [heap_ik_pkg::HEAP_DEPTH];
  heap_ik_pkg::val_t  mem_rdata_r;
  logic               mem_we;
  heap_ik_pkg::addr_t mem_waddr;
  heap_ik_pkg::val_t  mem_wdata;
  heap_ik_pkg::addr_t mem_raddr;

  heap_ik_pkg::pos_t  pos_m1;
  heap_ik_pkg::pos_t  par_pos;
  heap_ik_pkg::pos_t  par_m1;
  heap_ik_pkg::pos_t  gpar_m1;
  logic               pos_bad;
  logic [heap_ik_pkg::VALUE_BITS:0] sum;
  heap_ik_pkg::val_t  sat_sum;
  logic               out_free;

  assign pos_m1  = pos_r - heap_ik_pkg::POS_ROOT;
  assign par_pos = pos_r >> 1;
  assign par_m1  = par_pos - heap_ik_pkg::POS_ROOT;
  assign gpar_m1 = (pos_r >> 2) - heap_ik_pkg::POS_ROOT;
  assign pos_bad = (pos_r == '0) || (pos_r > heap_ik_pkg::POS_LIMIT);
  assign sum     = {1'b0, mem_rdata_r} + {1'b0, amt_r};
  assign sat_sum = sum[heap_ik_pkg::VALUE_BITS] ? '1 : sum[heap_ik_pkg::VALUE_BITS-1:0];
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_final_position = out_pos_r;
  assign out_read_value     = out_val_r;
  assign out_error          = out_err_r;

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    pos_nxt       = pos_r;
    amt_nxt       = amt_r;
    cur_nxt       = cur_r;
    res_pos_nxt   = res_pos_r;
    res_val_nxt   = res_val_r;
    res_err_nxt   = res_err_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_pos_nxt   = out_pos_r;
    out_val_nxt   = out_val_r;
    out_err_nxt   = out_err_r;
    mem_we        = 1'b0;
    mem_waddr     = pos_m1[heap_ik_pkg::ADDR_BITS-1:0];
    mem_wdata     = cur_r;
    mem_raddr     = pos_m1[heap_ik_pkg::ADDR_BITS-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_func;
          pos_nxt   = in_position;
          amt_nxt   = in_amount;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_pos_nxt = pos_r;
        res_val_nxt = '0;
        res_err_nxt = pos_bad && (func_r != heap_ik_pkg::FUNC_NONE);
        if (func_r == heap_ik_pkg::FUNC_NONE || pos_bad) begin
          state_nxt = S_DONE;
        end else if (func_r == heap_ik_pkg::FUNC_LOAD) begin
          mem_we    = 1'b1;
          mem_wdata = amt_r;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        if (func_r == heap_ik_pkg::FUNC_READ) begin
          res_val_nxt = mem_rdata_r;
          state_nxt   = S_DONE;
        end else if (pos_r == heap_ik_pkg::POS_ROOT) begin
          mem_we      = 1'b1;
          mem_wdata   = sat_sum;
          res_pos_nxt = pos_r;
          state_nxt   = S_DONE;
        end else begin
          cur_nxt   = sat_sum;
          mem_raddr = par_m1[heap_ik_pkg::ADDR_BITS-1:0];
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (cur_r > mem_rdata_r) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata_r;
          pos_nxt   = par_pos;
          if (par_pos == heap_ik_pkg::POS_ROOT) begin
            state_nxt = S_PLACE;
          end else begin
            mem_raddr = gpar_m1[heap_ik_pkg::ADDR_BITS-1:0];
          end
        end else begin
          mem_we      = 1'b1;
          res_pos_nxt = pos_r;
          state_nxt   = S_DONE;
        end
      end
      S_PLACE: begin
        mem_we      = 1'b1;
        res_pos_nxt = pos_r;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = res_pos_r;
          out_val_nxt   = res_val_r;
          out_err_nxt   = res_err_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    pos_r     <= pos_nxt;
    amt_r     <= amt_nxt;
    cur_r     <= cur_nxt;
    res_pos_r <= res_pos_nxt;
    res_val_r <= res_val_nxt;
    res_err_r <= res_err_nxt;
    out_pos_r <= out_pos_nxt;
    out_val_r <= out_val_nxt;
    out_err_r <= out_err_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

endmodule

`default_nettype wire

@@ design/heap_ik_checker.sv @@
// ----------------------------------------------------------------------------
// heap_ik_checker
// Port-level checks for the heap increase-key block, bound to the core module.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module heap_ik_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [10:0] out_final_position,
  input wire [31:0] out_read_value,
  input wire        out_error
);

  logic        in_take;
  logic        pos_out_of_range;
  logic [43:0] out_payload;

  assign in_take = in_valid && !in_stall;
  assign pos_out_of_range = (out_final_position == '0) ||
    (out_final_position > heap_ik_pkg::POS_LIMIT);
  assign out_payload = {out_final_position, out_read_value, out_error};

  `HIK_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_payload))
  `HIK_ASSERT_NEXT(a_one_request, clk, rst_n, in_take, in_stall)
  `HIK_ASSERT_NOW(a_err_pos, clk, rst_n, out_valid && out_error, pos_out_of_range)
  `HIK_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && out_error, out_read_value == '0)

endmodule

bind heap_increase_key_sift_up_core heap_ik_checker u_heap_ik_checker (.*);

`default_nettype wire

@@ dv/heap_increase_key_sift_up_checker.sv @@
// ----------------------------------------------------------------------------
// heap_increase_key_sift_up_checker
// Watches both channels of the heap increase-key core. For each accepted
// request, a local copy of the heap store predicts the result: load, read, and
// increase with saturation and sift-up. Each accepted result is compared field
// by field with the oldest prediction. The mismatch count and the number of
// predictions still waiting go to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module heap_increase_key_sift_up_checker
  import heap_ik_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  input  wire         in_stall,
  input  wire  [1:0]  in_func,
  input  wire  [10:0] in_position,
  input  wire  [31:0] in_amount,
  input  wire         out_valid,
  input  wire         out_stall,
  input  wire  [10:0] out_final_position,
  input  wire  [31:0] out_read_value,
  input  wire         out_error,
  output int          fail_count,
  output int          outstanding
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    pos_t final_position;
    val_t read_value;
    logic error;
  } heap_result_t;

  val_t         heap_mem [1:HEAP_DEPTH];
  heap_result_t pending_heap_results [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
    for (int i = 1; i <= HEAP_DEPTH; i++) heap_mem[i] = '0;
  end

  function automatic heap_result_t predict_heap_op(func_t op, pos_t pos, val_t amt);
    heap_result_t        res;
    pos_t                cur;
    pos_t                par;
    val_t                tmp;
    logic [VALUE_BITS:0] sum;
    logic                climbing;
    res.final_position = pos;
    res.read_value     = '0;
    res.error          = 1'b0;
    if (op != FUNC_NONE) begin
      if (pos < POS_ROOT || pos > POS_LIMIT) begin
        res.error = 1'b1;
      end else begin
        case (op)
          FUNC_LOAD: begin
            heap_mem[pos] = amt;
          end
          FUNC_INCREASE: begin
            sum = {1'b0, heap_mem[pos]} + {1'b0, amt};
            heap_mem[pos] = sum[VALUE_BITS] ? {VALUE_BITS{1'b1}} : sum[VALUE_BITS-1:0];
            cur      = pos;
            climbing = 1'b1;
            while (climbing && cur > POS_ROOT) begin
              par = cur >> 1;
              if (heap_mem[cur] > heap_mem[par]) begin
                tmp           = heap_mem[cur];
                heap_mem[cur] = heap_mem[par];
                heap_mem[par] = tmp;
                cur           = par;
              end else begin
                climbing = 1'b0;
              end
            end
            res.final_position = cur;
          end
          FUNC_READ: begin
            res.read_value = heap_mem[pos];
          end
          default: begin
          end
        endcase
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : compare
    heap_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_heap_results.size() == 0) begin
          if (fail_count < REPORT_LIMIT)
            $display("unexpected result: position %0d value %h error %0d",
                     out_final_position, out_read_value, out_error);
          fail_count++;
        end else begin
          want = pending_heap_results.pop_front();
          if (want.final_position !== out_final_position ||
              want.read_value !== out_read_value || want.error !== out_error) begin
            if (fail_count < REPORT_LIMIT)
              $display("mismatch: position exp %0d got %0d, value exp %h got %h, error exp %0d got %0d",
                       want.final_position, out_final_position, want.read_value,
                       out_read_value, want.error, out_error);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        pending_heap_results.push_back(predict_heap_op(in_func, in_position, in_amount));
    end
    outstanding <= pending_heap_results.size();
  end

endmodule

@@ dv/heap_increase_key_sift_up_core_test.sv @@
// ----------------------------------------------------------------------------
// heap_increase_key_sift_up_core_test
// Drives the heap increase-key core with a directed opening (extremes, a deep
// sift from the last position, saturation, out-of-range and unused requests)
// and then random requests of every kind, increases and reads only on loaded
// entries. Both sides idle in random bursts, and one long receiver hold-off
// backs the core up. The checker beside the core judges every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module heap_increase_key_sift_up_core_test;
  import heap_ik_pkg::*;

  localparam int   RANDOM_REQUESTS  = 400;
  localparam int   QUIET_TAIL       = 60;
  localparam int   LONG_HOLD_START  = 80;
  localparam int   LONG_HOLD_CYCLES = 300;
  localparam int   LIMIT_CYCLES     = 200000;
  localparam int   DRAIN_CYCLES     = 40;
  localparam int   POS_SPAN         = (1 << POS_BITS) - 1;
  localparam val_t VALUE_MAX        = {VALUE_BITS{1'b1}};

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        in_valid = 1'b0;
  logic [1:0]  in_func  = FUNC_LOAD;
  logic [10:0] in_position = '0;
  logic [31:0] in_amount   = '0;
  logic        out_stall   = 1'b0;
  wire         in_stall;
  wire         out_valid;
  wire  [10:0] out_final_position;
  wire  [31:0] out_read_value;
  wire         out_error;

  int fail_count;
  int outstanding;
  int sent_count = 0;
  int cycle_count = 0;
  bit quiet = 1'b0;
  bit loaded [1:HEAP_DEPTH];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  heap_increase_key_sift_up_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_func(in_func), .in_position(in_position), .in_amount(in_amount),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_final_position(out_final_position), .out_read_value(out_read_value),
    .out_error(out_error)
  );

  heap_increase_key_sift_up_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_func(in_func), .in_position(in_position), .in_amount(in_amount),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_final_position(out_final_position), .out_read_value(out_read_value),
    .out_error(out_error),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  function automatic bit chain_loaded(int p);
    bit ok;
    ok = 1'b1;
    while (p >= 1) begin
      ok = ok & loaded[p];
      p  = p / 2;
    end
    return ok;
  endfunction

  task automatic issue_request(func_t f, pos_t p, val_t a);
    if (f == FUNC_LOAD && p >= POS_ROOT && p <= POS_LIMIT) loaded[p] = 1'b1;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= f;
    in_position <= p;
    in_amount   <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  initial begin : receiver
    int hold_left;
    bit long_hold_done;
    hold_left      = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!long_hold_done && sent_count >= LONG_HOLD_START) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD_CYCLES;
      end else if (hold_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(1, 19);
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int    p;
    int    lvl;
    int    sel;
    int    useful;
    func_t f;
    val_t  a;
    for (int i = 1; i <= HEAP_DEPTH; i++) loaded[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // build a path from the last position to the root
    issue_request(FUNC_LOAD, pos_t'(1), 32'h8000_0000);
    issue_request(FUNC_LOAD, pos_t'(2), 32'h0000_0000);
    issue_request(FUNC_LOAD, pos_t'(3), 32'hFFFF_FFF0);
    lvl = 2;
    for (p = 4; p < HEAP_DEPTH; p = p * 2) begin
      issue_request(FUNC_LOAD, pos_t'(p), val_t'(lvl));
      lvl++;
    end
    issue_request(FUNC_LOAD, POS_LIMIT, 32'h0000_0000);

    issue_request(FUNC_INCREASE, POS_LIMIT, 32'h7FFF_FFFF);
    issue_request(FUNC_INCREASE, pos_t'(3), VALUE_MAX);
    issue_request(FUNC_INCREASE, POS_ROOT, 32'h0000_0000);
    issue_request(FUNC_INCREASE, pos_t'(2), 32'h8000_0000);
    issue_request(FUNC_READ, POS_ROOT, 32'h0000_0000);
    issue_request(FUNC_READ, POS_LIMIT, VALUE_MAX);

    issue_request(FUNC_LOAD, pos_t'(0), 32'h1234_5678);
    issue_request(FUNC_INCREASE, pos_t'(HEAP_DEPTH + 1), 32'h0000_0001);
    issue_request(FUNC_READ, pos_t'(POS_SPAN), 32'h0000_0000);
    issue_request(FUNC_LOAD, pos_t'(POS_SPAN), 32'hA5A5_5A5A);
    issue_request(FUNC_NONE, pos_t'(0), 32'h0000_0000);
    issue_request(FUNC_NONE, POS_LIMIT, VALUE_MAX);
    issue_request(FUNC_INCREASE, POS_LIMIT, 32'h0000_0001);

    useful = 0;
    while (useful < RANDOM_REQUESTS) begin
      sel = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0, 1: p = $urandom_range(1, HEAP_DEPTH);
        2: p = $urandom_range(HEAP_DEPTH / 2, HEAP_DEPTH);
        default: p = $urandom_range(1, 31);
      endcase
      case ($urandom_range(0, 7))
        0: a = '0;
        1: a = VALUE_MAX - val_t'($urandom_range(0, 15));
        2, 3: a = $urandom;
        default: a = val_t'($urandom_range(0, 255));
      endcase
      if (sel < 8) begin
        f = func_t'($urandom_range(0, 3));
        if (sel < 2) begin
          f = FUNC_NONE;
          p = $urandom_range(0, POS_SPAN);
        end else if (sel < 5) begin
          p = 0;
        end else begin
          p = $urandom_range(HEAP_DEPTH + 1, POS_SPAN);
        end
      end else begin
        useful++;
        if (sel < 40) begin
          f = FUNC_LOAD;
          if ($urandom_range(0, 1) == 0) a = $urandom;
        end else if (sel < 75) begin
          f = chain_loaded(p) ? FUNC_INCREASE : FUNC_LOAD;
        end else begin
          f = loaded[p] ? FUNC_READ : FUNC_LOAD;
        end
      end
      if (useful >= RANDOM_REQUESTS - QUIET_TAIL) quiet = 1'b1;
      issue_request(f, pos_t'(p), a);
    end
    in_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/heap_ik_pkg.sv
design/heap_increase_key_sift_up_core.sv
design/heap_ik_checker.sv
dv/heap_increase_key_sift_up_checker.sv
dv/heap_increase_key_sift_up_core_test.sv
